>>> src/fehp_pkg.sv
// Package for the fire effect heat propagation block: sizes, codes and the heat look-up.
package fehp_pkg;

   localparam int unsigned MAX_WIDTH   = 256;
   localparam int unsigned MAX_HEIGHT  = 128;
   localparam int unsigned HEAT_LEVELS = 13;
   localparam int unsigned MAP_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned ADDR_W      = $clog2(MAP_DEPTH);

   localparam logic [3:0] HEAT_MAX = 4'(HEAT_LEVELS - 1);

   localparam logic CMD_INIT = 1'b0;
   localparam logic CMD_STEP = 1'b1;

   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   localparam logic [8:0] WIDTH_RESET  = 9'd80;
   localparam logic [7:0] HEIGHT_RESET = 8'd24;
   localparam logic [8:0] WIDTH_MIN    = 9'd2;
   localparam logic [8:0] WIDTH_MAX    = 9'(MAX_WIDTH);
   localparam logic [7:0] HEIGHT_MIN   = 8'd2;
   localparam logic [7:0] HEIGHT_MAX   = 8'(MAX_HEIGHT);

   localparam logic [13:0] GLYPH_BLANK = 14'd32;
   localparam logic [3:0]  FG_BLANK    = 4'd9;
   localparam logic [2:0]  BG_BLANK    = 3'd0;

   localparam logic [13:0] SHADE_GLYPH [4] = '{14'h2591, 14'h2592, 14'h2593, 14'h2588};
   localparam logic [3:0]  TIER_FG     [4] = '{4'd2, 4'd4, 4'd8, 4'd8};
   localparam logic [2:0]  TIER_BG     [4] = '{3'd0, 3'd2, 3'd4, 3'd4};

   typedef struct packed {
      logic [13:0] glyph;
      logic [3:0]  fg;
      logic [2:0]  bg;
   } heat_look_type;

   function automatic heat_look_type heat_look(input logic [3:0] heat);
      heat_look_type look;
      logic [3:0]    hm1;
      hm1 = heat - 4'd1;
      if (heat == 4'd0) begin
         look.glyph = GLYPH_BLANK;
         look.fg    = FG_BLANK;
         look.bg    = BG_BLANK;
      end else begin
         look.glyph = SHADE_GLYPH[hm1[1:0]];
         look.fg    = TIER_FG[hm1[3:2]];
         look.bg    = TIER_BG[hm1[3:2]];
      end
      return look;
   endfunction

endpackage

>>> src/fire_effect_heat_propagation.sv
// Fire effect heat propagation: heat map memory, cell visit sequencer and result register.
// Update beat: heat memory read into a register on accept; write-back and result follow
// in the write state, held while the output stalls; requests wait until that state ends.
// Init beat: clears width*height cells, one per cycle, last row to full heat; no result.
// Reset: synchronous; size registers to 80 by 24, visit at column 0, row 1,
// heat map contents undefined until the first init.
module fire_effect_heat_propagation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [1:0] random_value
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // dest_index, dest_glyph, dest_fg, dest_bg,
                                    // source_index, source_glyph, source_fg, source_bg
   output logic        rsp_tlast,   // frame_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [8:0]  csr_data
);
   import fehp_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_WRITE, ST_CLEAR} state_type;

   state_type           state_ff;
   logic [8:0]          width_ff;
   logic [7:0]          height_ff;
   logic [7:0]          col_ff;
   logic [6:0]          row_ff;
   logic [7:0]          cur_x_ff;
   logic [6:0]          cur_y_ff;
   logic [ADDR_W-1:0]   src_ff;
   logic [ADDR_W-1:0]   dst_ff;
   logic                decay_ff;
   logic [ADDR_W:0]     clr_idx_ff;
   logic [ADDR_W:0]     clr_total_ff;
   logic [ADDR_W:0]     clr_base_ff;
   logic [3:0]          rd_data_ff;
   logic                rsp_tvalid_ff;
   logic [71:0]         rsp_tdata_ff;
   logic                rsp_tlast_ff;

   logic [3:0]          heat_mem [MAP_DEPTH];

   logic [8:0]          w_use;
   logic [7:0]          h_use;
   logic                restart;
   logic [7:0]          vis_x;
   logic [6:0]          vis_y;
   logic [ADDR_W:0]     src_in;
   logic [ADDR_W:0]     d_sum;
   logic [ADDR_W:0]     dst_in;
   logic [ADDR_W:0]     total_in;
   logic                req_accept;
   logic                rd_en;
   logic                out_free;
   logic                step_fire;
   logic [3:0]          new_heat;
   logic [7:0]          y_inc;
   logic [8:0]          x_inc;
   logic                col_wrap;
   logic                frame_wrap;
   logic [7:0]          col_in;
   logic [6:0]          row_in;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [3:0]          wr_data;
   heat_look_type       dest_look;
   heat_look_type       src_look;

   always_comb begin
      w_use = (width_ff < WIDTH_MIN) ? WIDTH_MIN :
              (width_ff > WIDTH_MAX) ? WIDTH_MAX : width_ff;
      h_use = (height_ff < HEIGHT_MIN) ? HEIGHT_MIN :
              (height_ff > HEIGHT_MAX) ? HEIGHT_MAX : height_ff;
      restart = ({1'b0, col_ff} >= w_use) || (row_ff == 7'd0) || ({1'b0, row_ff} >= h_use);
      vis_x = restart ? 8'd0 : col_ff;
      vis_y = restart ? 7'd1 : row_ff;
      src_in = (ADDR_W + 1)'(vis_y) * (ADDR_W + 1)'(w_use) + (ADDR_W + 1)'(vis_x);
      d_sum  = src_in + (ADDR_W + 1)'(1) - (ADDR_W + 1)'(req_tdata[1:0]);
      dst_in = (d_sum < (ADDR_W + 1)'(w_use)) ? '0 : d_sum - (ADDR_W + 1)'(w_use);
      total_in = (ADDR_W + 1)'(w_use) * (ADDR_W + 1)'(h_use);
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rd_en      = req_accept && (req_tuser == CMD_STEP);
   assign csr_ready  = 1'b1;

   assign out_free  = !rsp_tvalid_ff || rsp_tready;
   assign step_fire = (state_ff == ST_WRITE) && out_free;

   always_comb begin
      new_heat = (rd_data_ff >= {3'd0, decay_ff}) ? rd_data_ff - {3'd0, decay_ff} : 4'd0;
      if (new_heat > HEAT_MAX) begin
         new_heat = 4'd0;
      end
      y_inc      = {1'b0, cur_y_ff} + 8'd1;
      x_inc      = {1'b0, cur_x_ff} + 9'd1;
      col_wrap   = (y_inc >= h_use);
      frame_wrap = col_wrap && (x_inc >= w_use);
      row_in     = col_wrap ? 7'd1 : y_inc[6:0];
      col_in     = !col_wrap ? cur_x_ff : (frame_wrap ? 8'd0 : x_inc[7:0]);
      dest_look  = heat_look(new_heat);
      src_look   = heat_look(rd_data_ff);
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = dst_ff;
      wr_data = new_heat;
      unique case (state_ff)
         ST_WRITE: begin
            wr_en = out_free;
         end
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_ff[ADDR_W-1:0];
            wr_data = (clr_idx_ff < clr_base_ff) ? 4'd0 : HEAT_MAX;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heat_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= heat_mem[src_in[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
         col_ff        <= 8'd0;
         row_ff        <= 7'd1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_GRID_WIDTH:  width_ff  <= csr_data;
               CSR_GRID_HEIGHT: height_ff <= csr_data[7:0];
               default:         width_ff  <= width_ff;
            endcase
         end
         if (rsp_tready && !step_fire) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  if (req_tuser == CMD_INIT) begin
                     col_ff       <= 8'd0;
                     row_ff       <= 7'd1;
                     clr_idx_ff   <= '0;
                     clr_total_ff <= total_in;
                     clr_base_ff  <= total_in - (ADDR_W + 1)'(w_use);
                     state_ff     <= ST_CLEAR;
                  end else begin
                     cur_x_ff <= vis_x;
                     cur_y_ff <= vis_y;
                     src_ff   <= src_in[ADDR_W-1:0];
                     dst_ff   <= dst_in[ADDR_W-1:0];
                     decay_ff <= req_tdata[0];
                     state_ff <= ST_WRITE;
                  end
               end
            end
            ST_WRITE: begin
               if (out_free) begin
                  col_ff        <= col_in;
                  row_ff        <= row_in;
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tlast_ff  <= frame_wrap;
                  rsp_tdata_ff  <= {src_look.bg, src_look.fg, src_look.glyph, src_ff,
                                    dest_look.bg, dest_look.fg, dest_look.glyph, dst_ff};
                  state_ff      <= ST_IDLE;
               end
            end
            ST_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + (ADDR_W + 1)'(1);
               if (clr_idx_ff == clr_total_ff - (ADDR_W + 1)'(1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

>>> sim/testbench.sv
// Testbench for fire_effect_heat_propagation: heat-map predictor, scoreboard and stream drivers.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fehp_pkg::*;

   typedef struct {
      logic [71:0] data;
      logic        last;
   } cell_result_type;

   class heat_board_type;
      localparam int    FIELD_LO   [8] = '{0, 15, 29, 33, 36, 51, 65, 69};
      localparam int    FIELD_W    [8] = '{15, 14, 4, 3, 15, 14, 4, 3};
      localparam string FIELD_NAME [8] = '{"dest_index", "dest_glyph", "dest_fg", "dest_bg",
                                           "source_index", "source_glyph", "source_fg",
                                           "source_bg"};

      logic [8:0]      width_reg;
      logic [7:0]      height_reg;
      logic [7:0]      column;
      logic [6:0]      row;
      logic [3:0]      heat [MAP_DEPTH];
      bit              written [MAP_DEPTH];
      cell_result_type due_cells [$];
      int unsigned     sweep_left, errors, items, inits, checked, frames;

      function new();
         width_reg  = 9'd80;
         height_reg = 8'd24;
         column     = 8'd0;
         row        = 7'd1;
      endfunction

      function int unsigned bound(int unsigned v, int unsigned lo, int unsigned hi);
         return (v < lo) ? lo : (v > hi) ? hi : v;
      endfunction

      function int unsigned cols();
         return bound(width_reg, 2, MAX_WIDTH);
      endfunction

      function int unsigned rows();
         return bound(height_reg, 2, MAX_HEIGHT);
      endfunction

      function void set_reg(logic idx, logic [8:0] value);
         if (idx == CSR_GRID_WIDTH) begin
            width_reg = value;
         end else begin
            height_reg = value[7:0];
         end
      endfunction

      // {bg, fg, glyph} for one heat level
      function logic [20:0] shade(logic [3:0] lvl);
         int unsigned rank;
         logic [13:0] glyph;
         if (lvl == 4'd0) return {3'd0, 4'd9, 14'd32};
         rank = lvl - 1;
         case (rank % 4)
            0:       glyph = 14'h2591;
            1:       glyph = 14'h2592;
            2:       glyph = 14'h2593;
            default: glyph = 14'h2588;
         endcase
         case (rank / 4)
            0:       return {3'd0, 4'd2, glyph};
            1:       return {3'd2, 4'd4, glyph};
            default: return {3'd4, 4'd8, glyph};
         endcase
      endfunction

      // restart at column 0, row 1 when the counters fall outside the grid
      function int unsigned visit_cell();
         int unsigned w, h, x, y;
         w = cols();
         h = rows();
         x = column;
         y = row;
         if (x >= w || y == 0 || y >= h) begin
            x = 0;
            y = 1;
         end
         return y * w + x;
      endfunction

      function bit visit_is_seeded();
         return written[visit_cell()];
      endfunction

      function int unsigned pending();
         return due_cells.size();
      endfunction

      function void take_request(logic cmd, logic [1:0] rnd);
         int unsigned     w, h, src, dst, d, x, y;
         logic [3:0]      src_heat, new_heat;
         logic            done;
         cell_result_type r;
         w = cols();
         h = rows();
         items++;
         if (cmd == CMD_INIT) begin
            for (int unsigned i = 0; i < w * h; i++) begin
               heat[i]    = (i < w * h - w) ? 4'd0 : 4'(HEAT_LEVELS - 1);
               written[i] = 1'b1;
            end
            column     = 8'd0;
            row        = 7'd1;
            sweep_left = w * h;
            inits++;
            return;
         end
         sweep_left = 0;
         src = visit_cell();
         d   = src + 1 - rnd;
         dst = (d < w) ? 0 : d - w;
         src_heat = heat[src];
         new_heat = (src_heat >= rnd[0]) ? src_heat - rnd[0] : 4'd0;
         if (new_heat > HEAT_LEVELS - 1) new_heat = 4'd0;
         heat[dst]    = new_heat;
         written[dst] = 1'b1;
         src_heat = heat[src];
         x    = src % w;
         y    = src / w + 1;
         done = 1'b0;
         if (y >= h) begin
            y = 1;
            x++;
            if (x >= w) begin
               x    = 0;
               done = 1'b1;
               frames++;
            end
         end
         column = 8'(x);
         row    = 7'(y);
         r.data = {shade(src_heat), 15'(src), shade(new_heat), 15'(dst)};
         r.last = done;
         due_cells.push_back(r);
      endfunction

      task report(string what);
         errors++;
         if (errors <= 100) $display("mismatch: %s", what);
      endtask

      task check_response(logic [71:0] got, logic got_last);
         cell_result_type want;
         logic [71:0]     mask, got_f, want_f;
         if (due_cells.size() == 0) begin
            report($sformatf("result %h with no cell outstanding", got));
            return;
         end
         want = due_cells.pop_front();
         checked++;
         for (int f = 0; f < 8; f++) begin
            mask   = (72'd1 << FIELD_W[f]) - 72'd1;
            got_f  = (got >> FIELD_LO[f]) & mask;
            want_f = (want.data >> FIELD_LO[f]) & mask;
            if (got_f !== want_f) begin
               report($sformatf("cell %0d %s: got %0d, want %0d",
                                checked, FIELD_NAME[f], got_f, want_f));
            end
         end
         if (got_last !== want.last) begin
            report($sformatf("cell %0d frame_last: got %b, want %b",
                             checked, got_last, want.last));
         end
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [1:0] random_value
   logic        req_tuser  = 1'b0; // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;         // dest_index, dest_glyph, dest_fg, dest_bg,
                                   // source_index, source_glyph, source_fg, source_bg
   logic        rsp_tlast;         // frame_last
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_index  = 1'b0;
   logic [8:0]  csr_data   = '0;

   heat_board_type board;
   int unsigned    send_idle_pct = 0;
   int unsigned    stall_pct     = 0;
   int unsigned    hold_left     = 0;
   int unsigned    settings      = 0;
   logic           hold_flip     = 1'b0;
   logic           hold_seen     = 1'b0;

   fire_effect_heat_propagation DUT (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: random stalls, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_flip != hold_seen) begin
         hold_seen  <= hold_flip;
         hold_left  <= 300;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_response(rsp_tdata, rsp_tlast);
      end
   end

   initial begin
      #20_000_000;
      $display("[fire_effect_heat_propagation] ERROR");
      $finish;
   end

   task automatic send_item(logic cmd, logic [1:0] rnd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'd0, rnd};
      do @(posedge clock); while (!req_tready);
      board.take_request(cmd, rnd);
   endtask

   task automatic resize(logic [8:0] wv, logic [8:0] hv);
      csr_valid <= 1'b1;
      csr_index <= CSR_GRID_WIDTH;
      csr_data  <= wv;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(CSR_GRID_WIDTH, wv);
      csr_index <= CSR_GRID_HEIGHT;
      csr_data  <= hv;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(CSR_GRID_HEIGHT, hv);
      csr_valid <= 1'b0;
      settings++;
   endtask

   // drain outstanding cells, then let any clearing sweep finish
   task automatic settle();
      req_tvalid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (board.sweep_left + 20) @(posedge clock);
   endtask

   task automatic run_phase(int ph, int count);
      logic [8:0] wv, hv;
      logic       cmd;
      settle();
      case (ph % 4)
         0: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         1: begin
            send_idle_pct = 76;
            stall_pct     = 0;
         end
         2: begin
            send_idle_pct = 0;
            stall_pct     = 76;
         end
         default: begin
            send_idle_pct = 32;
            stall_pct     = 32;
         end
      endcase
      if (ph == 0) begin
         wv = 9'd2;
         hv = 9'd128;
      end else if (ph == 1) begin
         wv = 9'd256;
         hv = 9'd2;
      end else if (ph == 2 || $urandom_range(4) == 0) begin
         wv = 9'($urandom);
         hv = 9'($urandom);
      end else begin
         wv = 9'($urandom_range(2, 12));
         hv = 9'($urandom_range(2, 8));
      end
      resize(wv, hv);
      if (ph == 4) hold_flip <= ~hold_flip;
      repeat (count) begin
         if (!board.visit_is_seeded() ||
             (board.cols() * board.rows() <= 512 && $urandom_range(99) < 3)) begin
            cmd = CMD_INIT;
         end else begin
            cmd = CMD_STEP;
         end
         send_item(cmd, 2'($urandom_range(3)));
      end
   endtask

   initial begin
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // spread below the first row, decay of a cold cell
      send_item(CMD_INIT, 2'd0);
      send_item(CMD_STEP, 2'd3);
      send_item(CMD_INIT, 2'd1);
      send_item(CMD_STEP, 2'd2);
      send_item(CMD_STEP, 2'd1);
      send_item(CMD_STEP, 2'd0);
      settle();

      // smallest grid through clamping: hot sources, a frame every two cells
      resize(9'd0, 9'd1);
      send_item(CMD_INIT, 2'd2);
      send_item(CMD_STEP, 2'd0);
      send_item(CMD_STEP, 2'd1);
      send_item(CMD_STEP, 2'd2);
      send_item(CMD_STEP, 2'd3);
      send_item(CMD_STEP, 2'd1);
      send_item(CMD_STEP, 2'd3);
      settle();

      // largest grid through clamping, then shrink without init
      resize(9'h1FF, 9'h1FF);
      send_item(CMD_INIT, 2'd3);
      send_item(CMD_STEP, 2'd3);
      send_item(CMD_STEP, 2'd0);
      send_item(CMD_STEP, 2'd1);
      settle();
      resize(9'd256, 9'd2);
      send_item(CMD_STEP, 2'd1);
      send_item(CMD_STEP, 2'd2);

      for (int ph = 0; ph < 16; ph++) run_phase(ph, 94);

      req_tvalid <= 1'b0;
      for (int n = 0; n < 100000 && board.pending() != 0; n++) @(posedge clock);
      repeat (board.sweep_left + 20) @(posedge clock);
      if (board.pending() != 0) begin
         board.report($sformatf("%0d cells never reported", board.pending()));
      end

      $display("Covered %0d beats (%0d map inits) over %0d grid settings:",
               board.items, board.inits, settings + 1);
      $display("%0d cells checked, %0d frames closed; idling: none, sender 76%%,",
               board.checked, board.frames);
      $display("receiver 76%%, both 32%%, and one long receiver hold-off.");
      if (board.errors == 0) begin
         $display("[fire_effect_heat_propagation] OK");
      end else begin
         $display("[fire_effect_heat_propagation] ERROR");
      end
      $finish;
   end
endmodule
